/* rtl/core/kmsi_pkg.sv */
// Package for the keyboard matrix scan and interrupt block.
// Holds the matrix size, key codes and the beat types that the stages, the top level and the bench share.
package kmsi_pkg;

    localparam int ROW_COUNT = 4;

    localparam logic [15:0] ON_KEY_MASK = 16'h8000;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        key_pressed;
        logic [3:0]  key_row;
        logic [15:0] key_columns;
        logic [11:0] out_lines;
        logic        direct_read;
        logic        clear_in_state;
        logic        cpu_sleeping;
        logic        kbd_int_enable;
        logic        int_allowed;
        logic        machine_running;
    } kmsi_item_t;

    typedef struct packed {
        logic [15:0] in_register;
        logic        interrupt_request;
        logic        wake_request;
        logic        int_pending;
    } kmsi_result_t;

endpackage

/* rtl/core/kmsi_item_if.sv */
// Channel that carries key events and scan requests into the block.
// Stands alone; the payload fields match kmsi_pkg::kmsi_item_t.
interface kmsi_item_if;

    logic        valid;
    logic        ready;
    logic        kind;
    logic        key_pressed;
    logic [3:0]  key_row;
    logic [15:0] key_columns;
    logic [11:0] out_lines;
    logic        direct_read;
    logic        clear_in_state;
    logic        cpu_sleeping;
    logic        kbd_int_enable;
    logic        int_allowed;
    logic        machine_running;

    modport source (
        output valid, kind, key_pressed, key_row, key_columns, out_lines, direct_read,
               clear_in_state, cpu_sleeping, kbd_int_enable, int_allowed, machine_running,
        input  ready
    );

    modport sink (
        input  valid, kind, key_pressed, key_row, key_columns, out_lines, direct_read,
               clear_in_state, cpu_sleeping, kbd_int_enable, int_allowed, machine_running,
        output ready
    );

endinterface

/* rtl/core/kmsi_result_if.sv */
// Channel that carries one result beat per accepted item out of the block.
// Stands alone; the payload fields match kmsi_pkg::kmsi_result_t.
interface kmsi_result_if;

    logic        valid;
    logic        ready;
    logic [15:0] in_register;
    logic        interrupt_request;
    logic        wake_request;
    logic        int_pending;

    modport source (
        output valid, in_register, interrupt_request, wake_request, int_pending,
        input  ready
    );

    modport sink (
        input  valid, in_register, interrupt_request, wake_request, int_pending,
        output ready
    );

endinterface

/* rtl/core/kmsi_in_stage.sv */
// Input register of the keyboard block: captures one item beat per cycle while it is empty or advancing.
// Depends on kmsi_pkg and kmsi_item_if.
module kmsi_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    kmsi_item_if.sink           item,
    input  logic                advance,
    output logic                stage_valid,
    output kmsi_pkg::kmsi_item_t stage_item
);

    logic                 valid_reg;
    logic                 valid_next;
    kmsi_pkg::kmsi_item_t item_reg;
    logic                 take;

    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind            <= item.kind;
            item_reg.key_pressed     <= item.key_pressed;
            item_reg.key_row         <= item.key_row;
            item_reg.key_columns     <= item.key_columns;
            item_reg.out_lines       <= item.out_lines;
            item_reg.direct_read     <= item.direct_read;
            item_reg.clear_in_state  <= item.clear_in_state;
            item_reg.cpu_sleeping    <= item.cpu_sleeping;
            item_reg.kbd_int_enable  <= item.kbd_int_enable;
            item_reg.int_allowed     <= item.int_allowed;
            item_reg.machine_running <= item.machine_running;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

/* rtl/core/kmsi_engine.sv */
// Key matrix state and scan logic: row masks, ON flag, IN register, pending flag.
// Computes one result from the staged item and commits the state when it advances.
// Depends on kmsi_pkg.
module kmsi_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  kmsi_pkg::kmsi_item_t  cur,
    output kmsi_pkg::kmsi_result_t res
);

    logic [15:0] rows_reg [kmsi_pkg::ROW_COUNT];
    logic [15:0] rows_next [kmsi_pkg::ROW_COUNT];
    logic        on_reg;
    logic        on_next;
    logic [15:0] in_reg;
    logic [15:0] in_next;
    logic        pending_reg;
    logic        pending_next;

    logic        key_ok;
    logic        row_ok;
    logic        scan_en;
    logic        is_scan;
    logic        active;
    logic        edge_hit;
    logic        req;
    logic        irq;
    logic        wake;
    logic [15:0] gathered;

    always_comb
    begin
        is_scan = (cur.kind == kmsi_pkg::KIND_SCAN);
        key_ok  = (cur.kind == kmsi_pkg::KIND_KEY) && cur.machine_running;
        row_ok  = cur.key_row < 4'(kmsi_pkg::ROW_COUNT);
        scan_en = is_scan || (key_ok && row_ok);

        on_next = on_reg;
        for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
        begin
            rows_next[r] = rows_reg[r];
        end
        if (key_ok)
        begin
            if ((cur.key_columns & kmsi_pkg::ON_KEY_MASK) != 16'h0)
            begin
                on_next = cur.key_pressed;
            end
            for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
            begin
                if (cur.key_row == 4'(r))
                begin
                    rows_next[r] = cur.key_pressed ? (rows_reg[r] | cur.key_columns)
                                                   : (rows_reg[r] & ~cur.key_columns);
                end
            end
        end

        gathered = 16'h0;
        for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
        begin
            if (cur.out_lines[r])
            begin
                gathered = gathered | rows_next[r];
            end
        end
        if ((cur.out_lines != 12'h0) && on_next)
        begin
            gathered = gathered | kmsi_pkg::ON_KEY_MASK;
        end

        active   = (is_scan && cur.direct_read) || cur.cpu_sleeping || on_next
                   || cur.kbd_int_enable;
        edge_hit = ((gathered != 16'h0) && (in_reg == 16'h0))
                   || (is_scan && cur.clear_in_state);
        req      = ((edge_hit && cur.kbd_int_enable) || ((in_reg == 16'h0) && on_next))
                   && cur.int_allowed;

        in_next      = in_reg;
        pending_next = pending_reg;
        irq          = 1'b0;
        wake         = 1'b0;
        if (scan_en)
        begin
            if (!active)
            begin
                in_next = in_reg & ~kmsi_pkg::ON_KEY_MASK;
            end
            else
            begin
                in_next = gathered;
                if (gathered != 16'h0)
                begin
                    pending_next = pending_reg || (edge_hit && !cur.kbd_int_enable);
                    irq          = req;
                    wake         = cur.cpu_sleeping;
                end
                else
                begin
                    pending_next = 1'b0;
                end
            end
        end

        res.in_register       = in_next;
        res.interrupt_request = irq;
        res.wake_request      = wake;
        res.int_pending       = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
            begin
                rows_reg[r] <= 16'h0;
            end
            on_reg      <= 1'b0;
            in_reg      <= 16'h0;
            pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
            begin
                rows_reg[r] <= rows_next[r];
            end
            on_reg      <= on_next;
            in_reg      <= in_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* rtl/core/keyboard_matrix_scan_interrupt.sv */
// Keyboard matrix scan and interrupt block, top level.
// An accepted item beat is held in kmsi_in_stage, then its result is registered in the output register.
// Throughput: one item per cycle while the result sink takes beats; kmsi_engine commits its state on each advance.
// Reset clears the row masks, the ON flag, the IN register, the pending flag and all valids.
// Depends on kmsi_pkg, kmsi_item_if, kmsi_result_if, kmsi_in_stage and kmsi_engine.
module keyboard_matrix_scan_interrupt (
    input  logic          clk,
    input  logic          rst_n,
    kmsi_item_if.sink     item,
    kmsi_result_if.source result
);

    logic                   stage_valid;
    kmsi_pkg::kmsi_item_t   stage_item;
    kmsi_pkg::kmsi_result_t res;
    kmsi_pkg::kmsi_result_t res_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_free;
    logic                   advance;

    assign out_free       = !out_valid_reg || result.ready;
    assign advance        = stage_valid && out_free;
    assign out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    kmsi_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    kmsi_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cur     (stage_item),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.in_register       = res_reg.in_register;
    assign result.interrupt_request = res_reg.interrupt_request;
    assign result.wake_request      = res_reg.wake_request;
    assign result.int_pending       = res_reg.int_pending;

    a_irq_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.interrupt_request) |-> (result.in_register != 16'h0))
        else $error("interrupt request with an empty IN register");

    a_wake_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.wake_request) |-> (result.in_register != 16'h0))
        else $error("wake request with an empty IN register");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item did not reach the output register");

    a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !out_free) |-> !item.ready)
        else $error("input accepted while the pipeline is full and stalled");

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for keyboard_matrix_scan_interrupt: directed, random and stall tests.
// Depends on kmsi_pkg, kmsi_item_if, kmsi_result_if and the block's RTL; needs no other file.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ROW_BITS = $clog2(kmsi_pkg::ROW_COUNT);

    logic clk;
    logic rst_n;

    kmsi_item_if   item_bus ();
    kmsi_result_if result_bus ();

    keyboard_matrix_scan_interrupt dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    logic [15:0] held_rows [kmsi_pkg::ROW_COUNT];
    logic        on_held = 1'b0;
    logic [15:0] in_shadow = '0;
    logic        pending_shadow = 1'b0;

    kmsi_pkg::kmsi_result_t matrix_outcomes [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  counted_items = 0;
    int  sink_hold_request = 0;
    bit  source_throttle = 1'b0;
    bit  sink_throttle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void scan_matrix(input logic [11:0] lines, input logic direct,
                                        input logic forced, input logic sleeping,
                                        input logic enable, input logic allowed,
                                        output logic irq, output logic wake);
        logic [15:0] prev_in;
        logic [15:0] gathered;
        logic        rise;
        logic        req;
        irq = 1'b0;
        wake = 1'b0;
        if (!(direct || sleeping || on_held || enable))
        begin
            in_shadow = in_shadow & ~kmsi_pkg::ON_KEY_MASK;
        end
        else
        begin
            prev_in = in_shadow;
            gathered = '0;
            if (lines != '0)
            begin
                for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
                begin
                    if (lines[r])
                        gathered = gathered | held_rows[r];
                end
                if (on_held)
                    gathered = gathered | kmsi_pkg::ON_KEY_MASK;
            end
            in_shadow = gathered;
            rise = (gathered != '0 && prev_in == '0) || forced;
            pending_shadow = pending_shadow || (rise && !enable);
            req = ((rise && enable) || (prev_in == '0 && on_held)) && allowed;
            if (gathered != '0)
            begin
                irq = req;
                wake = sleeping;
            end
            else
            begin
                pending_shadow = 1'b0;
            end
        end
    endfunction

    function automatic kmsi_pkg::kmsi_result_t predict_matrix(input kmsi_pkg::kmsi_item_t it);
        kmsi_pkg::kmsi_result_t res;
        logic                   irq;
        logic                   wake;
        logic [ROW_BITS-1:0]    row_idx;
        irq = 1'b0;
        wake = 1'b0;
        row_idx = it.key_row[ROW_BITS-1:0];
        if (it.kind == kmsi_pkg::KIND_SCAN)
        begin
            scan_matrix(it.out_lines, it.direct_read, it.clear_in_state, it.cpu_sleeping,
                        it.kbd_int_enable, it.int_allowed, irq, wake);
        end
        else if (it.machine_running)
        begin
            if ((it.key_columns & kmsi_pkg::ON_KEY_MASK) != '0)
                on_held = it.key_pressed;
            if (it.key_row < kmsi_pkg::ROW_COUNT)
            begin
                if (it.key_pressed)
                    held_rows[row_idx] = held_rows[row_idx] | it.key_columns;
                else
                    held_rows[row_idx] = held_rows[row_idx] & ~it.key_columns;
                scan_matrix(it.out_lines, 1'b0, 1'b0, it.cpu_sleeping,
                            it.kbd_int_enable, it.int_allowed, irq, wake);
            end
        end
        res.in_register = in_shadow;
        res.interrupt_request = irq;
        res.wake_request = wake;
        res.int_pending = pending_shadow;
        return res;
    endfunction

    task automatic send_item_beat(input kmsi_pkg::kmsi_item_t it);
        @(negedge clk);
        item_bus.valid = 1'b1;
        item_bus.kind = it.kind;
        item_bus.key_pressed = it.key_pressed;
        item_bus.key_row = it.key_row;
        item_bus.key_columns = it.key_columns;
        item_bus.out_lines = it.out_lines;
        item_bus.direct_read = it.direct_read;
        item_bus.clear_in_state = it.clear_in_state;
        item_bus.cpu_sleeping = it.cpu_sleeping;
        item_bus.kbd_int_enable = it.kbd_int_enable;
        item_bus.int_allowed = it.int_allowed;
        item_bus.machine_running = it.machine_running;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        matrix_outcomes.push_back(predict_matrix(it));
        if (it.kind == kmsi_pkg::KIND_SCAN || it.machine_running)
            counted_items++;
    endtask

    task automatic source_pause(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            item_bus.valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic paced_send(input kmsi_pkg::kmsi_item_t it);
        if (source_throttle)
            source_pause(draw_gap());
        send_item_beat(it);
    endtask

    task automatic wait_for_results();
        source_pause(1);
        while (matrix_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic kmsi_pkg::kmsi_item_t key_beat(input logic pressed,
                                                      input logic [3:0] row,
                                                      input logic [15:0] cols,
                                                      input logic [11:0] lines,
                                                      input logic sleeping,
                                                      input logic enable,
                                                      input logic allowed,
                                                      input logic running);
        kmsi_pkg::kmsi_item_t it;
        it = '0;
        it.kind = kmsi_pkg::KIND_KEY;
        it.key_pressed = pressed;
        it.key_row = row;
        it.key_columns = cols;
        it.out_lines = lines;
        it.cpu_sleeping = sleeping;
        it.kbd_int_enable = enable;
        it.int_allowed = allowed;
        it.machine_running = running;
        return it;
    endfunction

    function automatic kmsi_pkg::kmsi_item_t scan_beat(input logic [11:0] lines,
                                                       input logic direct,
                                                       input logic clear,
                                                       input logic sleeping,
                                                       input logic enable,
                                                       input logic allowed);
        kmsi_pkg::kmsi_item_t it;
        it = '0;
        it.kind = kmsi_pkg::KIND_SCAN;
        it.out_lines = lines;
        it.direct_read = direct;
        it.clear_in_state = clear;
        it.cpu_sleeping = sleeping;
        it.kbd_int_enable = enable;
        it.int_allowed = allowed;
        it.machine_running = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic kmsi_pkg::kmsi_item_t random_matrix_item();
        kmsi_pkg::kmsi_item_t it;
        int                   r;
        it.kind = ($urandom_range(0, 1) != 0) ? kmsi_pkg::KIND_SCAN : kmsi_pkg::KIND_KEY;
        it.key_pressed = ($urandom_range(0, 99) < 55);
        it.key_row = ($urandom_range(0, 99) < 85)
                     ? 4'($urandom_range(0, kmsi_pkg::ROW_COUNT - 1))
                     : 4'($urandom_range(kmsi_pkg::ROW_COUNT, 15));
        r = $urandom_range(0, 99);
        if (r < 55)
            it.key_columns = 16'h0001 << $urandom_range(0, 14);
        else if (r < 70)
            it.key_columns = kmsi_pkg::ON_KEY_MASK;
        else if (r < 90)
            it.key_columns = 16'($urandom_range(0, 65535));
        else if (r < 95)
            it.key_columns = 16'hFFFF;
        else
            it.key_columns = '0;
        r = $urandom_range(0, 99);
        if (r < 70)
            it.out_lines = 12'($urandom_range(0, 4095));
        else if (r < 85)
            it.out_lines = 12'($urandom_range(1, 15));
        else if (r < 95)
            it.out_lines = '0;
        else
            it.out_lines = 12'($urandom_range(1, 255)) << 4;
        it.direct_read = 1'($urandom_range(0, 1));
        it.clear_in_state = ($urandom_range(0, 99) < 15);
        it.cpu_sleeping = ($urandom_range(0, 99) < 30);
        it.kbd_int_enable = 1'($urandom_range(0, 1));
        it.int_allowed = ($urandom_range(0, 99) < 70);
        it.machine_running = ($urandom_range(0, 99) < 90);
        return it;
    endfunction

    task automatic keystroke_sequence();
        kmsi_pkg::kmsi_item_t it;
        logic [3:0]           row;
        logic [15:0]          cols;
        int                   scans;
        row = 4'($urandom_range(0, kmsi_pkg::ROW_COUNT - 1));
        cols = ($urandom_range(0, 4) == 0)
               ? (kmsi_pkg::ON_KEY_MASK | (16'h0001 << $urandom_range(0, 14)))
               : (16'h0001 << $urandom_range(0, 14));
        it = random_matrix_item();
        it.kind = kmsi_pkg::KIND_KEY;
        it.machine_running = 1'b1;
        it.key_pressed = 1'b1;
        it.key_row = row;
        it.key_columns = cols;
        paced_send(it);
        scans = $urandom_range(1, 3);
        repeat (scans)
        begin
            it = random_matrix_item();
            it.kind = kmsi_pkg::KIND_SCAN;
            if ($urandom_range(0, 9) != 0)
                it.out_lines[row] = 1'b1;
            paced_send(it);
        end
        it = random_matrix_item();
        it.kind = kmsi_pkg::KIND_KEY;
        it.machine_running = 1'b1;
        it.key_pressed = 1'b0;
        it.key_row = row;
        it.key_columns = cols;
        paced_send(it);
        it = random_matrix_item();
        it.kind = kmsi_pkg::KIND_SCAN;
        paced_send(it);
    endtask

    task automatic test_directed_cases();
        source_throttle = 1'b0;
        sink_throttle = 1'b0;
        send_item_beat(scan_beat(12'h000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item_beat(key_beat(1'b1, 4'd0, 16'hFFFF, 12'h001, 1'b0, 1'b1, 1'b1, 1'b0));
        send_item_beat(key_beat(1'b1, 4'd0, 16'h0001, 12'h001, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item_beat(key_beat(1'b1, 4'd3, 16'h7FFE, 12'hFFF, 1'b1, 1'b0, 1'b1, 1'b1));
        send_item_beat(key_beat(1'b1, 4'd15, kmsi_pkg::ON_KEY_MASK, 12'h00F,
                                1'b0, 1'b0, 1'b1, 1'b1));
        send_item_beat(scan_beat(12'h000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item_beat(scan_beat(12'h00F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item_beat(scan_beat(12'h00F, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
        send_item_beat(scan_beat(12'hFF0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item_beat(scan_beat(12'h002, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        send_item_beat(key_beat(1'b0, 4'd4, kmsi_pkg::ON_KEY_MASK, 12'h00F,
                                1'b0, 1'b1, 1'b1, 1'b1));
        send_item_beat(key_beat(1'b1, 4'd2, 16'hAAAA, 12'h004, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item_beat(key_beat(1'b1, 4'd1, 16'h5555, 12'h00A, 1'b1, 1'b1, 1'b1, 1'b1));
        send_item_beat(scan_beat(12'h008, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item_beat(scan_beat(12'h005, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
            send_item_beat(key_beat(1'b0, 4'(r), 16'hFFFF, 12'h001, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item_beat(scan_beat(12'hFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item_beat(key_beat(1'b1, 4'd7, 16'h8001, 12'hABC, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item_beat(scan_beat(12'hFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item_beat(key_beat(1'b0, 4'd9, kmsi_pkg::ON_KEY_MASK, 12'h100,
                                1'b1, 1'b0, 1'b1, 1'b1));
        send_item_beat(scan_beat(12'h0FF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int target);
        int first;
        first = counted_items;
        while (counted_items - first < target)
        begin
            if ((counted_items - first) % 200 < 8)
            begin
                source_throttle = ($urandom_range(0, 3) != 0);
                sink_throttle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 60)
                keystroke_sequence();
            else
                paced_send(random_matrix_item());
        end
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        source_throttle = 1'b0;
        sink_throttle = 1'b0;
        @(negedge clk);
        sink_hold_request = 300;
        repeat (2) @(negedge clk);
        repeat (60)
            send_item_beat(random_matrix_item());
        wait_for_results();
    endtask

    task automatic test_paused_phases();
        source_throttle = 1'b1;
        sink_throttle = 1'b1;
        repeat (4)
        begin
            repeat (12)
                keystroke_sequence();
            wait_for_results();
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_request > 0)
            begin
                stall_left = sink_hold_request;
                sink_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                result_bus.ready = 1'b0;
                stall_left--;
            end
            else if (sink_throttle && draw_gap() > 0)
            begin
                result_bus.ready = 1'b0;
                stall_left = draw_gap();
            end
            else
            begin
                result_bus.ready = 1'b1;
            end
        end
    end

    initial
    begin
        kmsi_pkg::kmsi_result_t got;
        kmsi_pkg::kmsi_result_t want;
        bit                     seen;
        forever
        begin
            @(posedge clk);
            seen = rst_n && result_bus.valid && result_bus.ready;
            got.in_register = result_bus.in_register;
            got.interrupt_request = result_bus.interrupt_request;
            got.wake_request = result_bus.wake_request;
            got.int_pending = result_bus.int_pending;
            @(negedge clk);
            if (seen)
            begin
                if (matrix_outcomes.size() == 0)
                begin
                    $error("result beat with nothing expected: in_register %h", got.in_register);
                    mismatches++;
                end
                else
                begin
                    want = matrix_outcomes.pop_front();
                    if (got.in_register !== want.in_register)
                    begin
                        $error("in_register: expected %h, actual %h",
                               want.in_register, got.in_register);
                        mismatches++;
                    end
                    if (got.interrupt_request !== want.interrupt_request)
                    begin
                        $error("interrupt_request: expected %b, actual %b",
                               want.interrupt_request, got.interrupt_request);
                        mismatches++;
                    end
                    if (got.wake_request !== want.wake_request)
                    begin
                        $error("wake_request: expected %b, actual %b",
                               want.wake_request, got.wake_request);
                        mismatches++;
                    end
                    if (got.int_pending !== want.int_pending)
                    begin
                        $error("int_pending: expected %b, actual %b",
                               want.int_pending, got.int_pending);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.kind = kmsi_pkg::KIND_KEY;
        item_bus.key_pressed = 1'b0;
        item_bus.key_row = '0;
        item_bus.key_columns = '0;
        item_bus.out_lines = '0;
        item_bus.direct_read = 1'b0;
        item_bus.clear_in_state = 1'b0;
        item_bus.cpu_sleeping = 1'b0;
        item_bus.kbd_int_enable = 1'b0;
        item_bus.int_allowed = 1'b0;
        item_bus.machine_running = 1'b0;
        for (int r = 0; r < kmsi_pkg::ROW_COUNT; r++)
            held_rows[r] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_random_traffic(2000);
        test_paused_phases();

        if (mismatches == 0 && matrix_outcomes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/kmsi_pkg.sv
rtl/core/kmsi_item_if.sv
rtl/core/kmsi_result_if.sv
rtl/core/kmsi_in_stage.sv
rtl/core/kmsi_engine.sv
rtl/core/keyboard_matrix_scan_interrupt.sv
bench/tb_top.sv
